// File: hw/rtl/rfr_pkg.sv
// shared constants and types for the reply frame receiver
`default_nettype none

package rfr_pkg;

    localparam int PAYLOAD_BYTES = 6;
    localparam int STORE_BYTES   = 6;
    localparam int CNT_W         = 3;
    localparam int WORD_W        = 16;
    localparam int WORDS         = 3;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_HDR2  = 3'd1;
    localparam logic [2:0] PH_FUNC  = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;

    localparam logic CFG_IDX_EXP_FUNC = 1'b0;

    typedef struct packed {
        logic                        frame_ok;
        logic [WORDS*WORD_W-1:0]     words;
    } t_rfr_result;

endpackage

`default_nettype wire

// File: hw/rtl/reply_frame_receiver_unit.sv
// top level of the reply frame receiver: register port and deframer
// Takes one received byte per transfer on the slave stream and can accept a byte in every
// cycle unless a checksum byte waits on a stalled result. A frame is 0xAA, 0x55, the function
// byte (must match the expected_function register, address 0x0, reset 0x11), the length byte
// (must be 6), six payload bytes and a checksum byte equal to the complement of the 8-bit sum
// of function, length and payload. Bad header, function or length bytes silently restart the
// hunt; the checksum byte always yields one result transfer with tuser set when the checksum
// matched. A byte passes an input register and the frame state logic, and the result is
// captured in a single result register that holds it while the master side stalls; a further
// checksum byte waits in the input register until it is taken.
`default_nettype none

module reply_frame_receiver_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [7:0]   i_s_axis_tdata,   // rx_byte
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [47:0]       o_m_axis_tdata,   // word_0, word_1, word_2
    output logic              o_m_axis_tuser    // frame_ok
);
    import rfr_pkg::*;

    logic [7:0]  r_expected_function;
    t_rfr_result w_result;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_function <= 8'd17;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == CFG_IDX_EXP_FUNC) begin
            r_expected_function <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            CFG_IDX_EXP_FUNC: prdata = {24'd0, r_expected_function};
            default:          prdata = '0;
        endcase
    end

    rfr_deframer u_deframer (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_expected_function (r_expected_function),
        .i_in_valid          (i_s_axis_tvalid),
        .o_in_ready          (o_s_axis_tready),
        .i_in_byte           (i_s_axis_tdata),
        .o_out_valid         (o_m_axis_tvalid),
        .i_out_ready         (i_m_axis_tready),
        .o_out_result        (w_result)
    );

    assign o_m_axis_tdata = w_result.words;
    assign o_m_axis_tuser = w_result.frame_ok;

endmodule

`default_nettype wire

// File: hw/rtl/rfr_deframer.sv
// frame hunting state machine, payload capture and checksum check
`default_nettype none

module rfr_deframer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [7:0]         i_expected_function,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_in_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rfr_pkg::t_rfr_result    o_out_result
);
    import rfr_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic [2:0]             r_phase, n_phase;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [7:0]             r_sum, n_sum;
    logic [8*STORE_BYTES-1:0] r_store, n_store;
    logic                   r_out_valid;
    t_rfr_result            r_out_result;
    logic                   w_is_check;
    logic                   w_advance;
    logic                   w_last_data;

    assign w_is_check  = (r_phase == PH_CHECK);
    assign w_advance   = r_in_valid && (!w_is_check || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_last_data = (({1'b0, r_count} + {{CNT_W{1'b0}}, 1'b1}) >=
                          (CNT_W + 1)'(PAYLOAD_BYTES));

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_sum   = r_sum;
        n_store = r_store;
        unique case (r_phase)
            PH_HDR2: begin
                n_phase = (r_in_byte == HDR_SECOND) ? PH_FUNC : PH_HUNT;
            end
            PH_FUNC: begin
                if (r_in_byte == i_expected_function) begin
                    n_sum   = r_in_byte;
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_LEN: begin
                if (r_in_byte == 8'(PAYLOAD_BYTES)) begin
                    n_sum   = r_sum + r_in_byte;
                    n_count = '0;
                    n_store = '0;
                    n_phase = PH_DATA;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                for (int k = 0; k < STORE_BYTES; k++) begin
                    if (r_count == CNT_W'(k)) begin
                        n_store[8*k +: 8] = r_in_byte;
                    end
                end
                n_sum = r_sum + r_in_byte;
                if (w_last_data) begin
                    n_count = '0;
                    n_phase = PH_CHECK;
                end else begin
                    n_count = r_count + {{(CNT_W-1){1'b0}}, 1'b1};
                end
            end
            PH_CHECK: begin
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = (r_in_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_HUNT;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_sum   <= n_sum;
            end
            if (w_advance && w_is_check) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
        if (w_advance) begin
            r_store <= n_store;
        end
        if (w_advance && w_is_check) begin
            r_out_result.frame_ok <= ((~r_sum) == r_in_byte);
            r_out_result.words    <= r_store[WORDS*WORD_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out_result;

`ifndef SYNTHESIS
    a_result_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_phase) == PH_CHECK)
        else $error("result raised outside checksum phase");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} < (CNT_W + 1)'(PAYLOAD_BYTES)))
        else $error("payload count out of range");

    a_data_next_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_phase == PH_DATA) |=> (r_phase == PH_DATA || r_phase == PH_CHECK))
        else $error("payload phase left to wrong phase");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_reply_frame_receiver_unit.sv
// self-checking testbench for the reply frame receiver: frame stimulus, deframing predictor
`timescale 1ns / 1ps

module tb_reply_frame_receiver_unit;
    import rfr_pkg::*;

    localparam logic [7:0] FUNC_AT_RESET = 8'd17;
    localparam int         LATENCY       = 4;
    localparam int         FRAME_BYTES   = PAYLOAD_BYTES + 5;
    localparam int         RANDOM_ITEMS  = 200;
    localparam int         HOLD_CYCLES   = 150;
    localparam longint     TIMEOUT_NS    = 200_000 * 12;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata = '0;   // rx_byte
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [47:0]  o_m_axis_tdata;        // word_0, word_1, word_2
    logic         o_m_axis_tuser;        // frame_ok

    // deframer state as the testbench sees it
    logic [7:0]              exp_func = FUNC_AT_RESET;
    logic [2:0]              rx_phase = PH_HUNT;
    logic [CNT_W-1:0]        pay_cnt = '0;
    logic [7:0]              cks_sum = '0;
    logic [8*STORE_BYTES-1:0] pay_store = '0;

    t_rfr_result reply_q[$];
    t_rfr_result want_reply;

    int fail_count = 0;
    int bytes_taken = 0;
    int replies_checked = 0;
    int bad_cks_replies = 0;
    int func_writes = 0;
    int tx_gap_max = 9;
    int rx_gap_max = 9;
    int rx_hold = 0;

    reply_frame_receiver_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function void deframe_byte(input logic [7:0] b);
        t_rfr_result reply;
        logic [7:0]  cks_want;
        case (rx_phase)
            PH_HDR2: begin
                rx_phase = (b == HDR_SECOND) ? PH_FUNC : PH_HUNT;
            end
            PH_FUNC: begin
                if (b == exp_func) begin
                    cks_sum  = b;
                    rx_phase = PH_LEN;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_LEN: begin
                if (b == 8'(PAYLOAD_BYTES)) begin
                    cks_sum   = cks_sum + b;
                    pay_cnt   = '0;
                    pay_store = '0;
                    rx_phase  = PH_DATA;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                if (pay_cnt < STORE_BYTES)
                    pay_store[8*pay_cnt +: 8] = b;
                cks_sum = cks_sum + b;
                if (int'(pay_cnt) + 1 >= PAYLOAD_BYTES) begin
                    pay_cnt  = '0;
                    rx_phase = PH_CHECK;
                end else begin
                    pay_cnt = pay_cnt + 1'b1;
                end
            end
            PH_CHECK: begin
                cks_want       = ~cks_sum;
                reply.frame_ok = (cks_want == b);
                reply.words    = pay_store;
                reply_q.push_back(reply);
                rx_phase = PH_HUNT;
            end
            default: begin
                rx_phase = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                bytes_taken++;
                deframe_byte(i_s_axis_tdata);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: reply with none expected, tuser %0b tdata %h", $time,
                             o_m_axis_tuser, o_m_axis_tdata);
                    fail_count++;
                end else begin
                    want_reply = reply_q.pop_front();
                    replies_checked++;
                    if (!want_reply.frame_ok)
                        bad_cks_replies++;
                    if (o_m_axis_tuser !== want_reply.frame_ok) begin
                        $display("%0t: frame_ok expected %0b actual %0b", $time,
                                 want_reply.frame_ok, o_m_axis_tuser);
                        fail_count++;
                    end
                    for (int w = 0; w < WORDS; w++) begin
                        if (o_m_axis_tdata[WORD_W*w +: WORD_W] !==
                            want_reply.words[WORD_W*w +: WORD_W]) begin
                            $display("%0t: word_%0d expected %h actual %h", $time, w,
                                     want_reply.words[WORD_W*w +: WORD_W],
                                     o_m_axis_tdata[WORD_W*w +: WORD_W]);
                            fail_count++;
                        end
                    end
                end
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        forever begin
            if (rx_hold > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            stall = $urandom_range(0, rx_gap_max);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // header and function; length and the rest only if the block would take them
    task automatic send_frame(input logic [7:0] func, input logic [7:0] len,
                              input logic [8*STORE_BYTES-1:0] pay, input logic [7:0] flip);
        logic [7:0] sum;
        logic [7:0] b;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(func);
        if (func != exp_func)
            return;
        send_byte(len);
        if (len != 8'(PAYLOAD_BYTES))
            return;
        sum = func + len;
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            b   = (k < STORE_BYTES) ? pay[8*k +: 8] : 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        send_byte(~sum ^ flip);
    endtask

    task automatic wait_for_replies();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reply_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_function(input logic [7:0] value);
        wait_for_replies();
        repeat (LATENCY) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {CFG_IDX_EXP_FUNC, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        exp_func = value;
        func_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [8*STORE_BYTES-1:0] random_payload();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic test_directed();
        send_frame(exp_func, 8'(PAYLOAD_BYTES), '0, 8'd0);
        // repeated first header byte restarts the hunt
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        // wrong function byte
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(exp_func ^ 8'h01);
        // wrong length byte
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(exp_func);
        send_byte(8'hFF);
        // checksum mismatch still gives a reply
        send_frame(exp_func, 8'(PAYLOAD_BYTES), '1, 8'hFF);
        wait_for_replies();
    endtask

    task automatic test_function_codes();
        logic [7:0] codes[$];
        codes = '{8'h00, 8'hFF, HDR_FIRST, HDR_SECOND, 8'($urandom), FUNC_AT_RESET};
        foreach (codes[i]) begin
            set_function(codes[i]);
            send_frame(codes[i], 8'(PAYLOAD_BYTES), random_payload(), 8'd0);
            send_frame(codes[i] ^ 8'h80, 8'(PAYLOAD_BYTES), random_payload(), 8'd0);
            send_frame(codes[i], 8'(PAYLOAD_BYTES), random_payload(),
                       8'($urandom_range(1, 255)));
        end
        wait_for_replies();
    endtask

    task automatic test_backpressure();
        wait_for_replies();
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold    = HOLD_CYCLES;
        repeat (12) send_frame(exp_func, 8'(PAYLOAD_BYTES), random_payload(), 8'd0);
        tx_gap_max = 9;
        rx_gap_max = 9;
        wait_for_replies();
    endtask

    task automatic test_drain_pause();
        repeat (4) begin
            repeat (3) begin
                send_frame(exp_func, 8'(PAYLOAD_BYTES), random_payload(),
                           ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
            end
            wait_for_replies();
        end
    endtask

    task automatic test_random_stream(input int target);
        int         items;
        int         pick;
        logic [7:0] b;
        items = 0;
        while (items < target) begin
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_frame(exp_func, 8'(PAYLOAD_BYTES), random_payload(), 8'd0);
                items += FRAME_BYTES;
            end else if (pick < 72) begin
                send_frame(exp_func, 8'(PAYLOAD_BYTES), random_payload(),
                           8'($urandom_range(1, 255)));
                items += FRAME_BYTES;
            end else if (pick < 80) begin
                send_frame(exp_func ^ 8'($urandom_range(1, 255)), 8'(PAYLOAD_BYTES),
                           random_payload(), 8'd0);
                items += 3;
            end else if (pick < 86) begin
                b = 8'($urandom);
                if (b == 8'(PAYLOAD_BYTES))
                    b = 8'd0;
                send_frame(exp_func, b, random_payload(), 8'd0);
                items += 4;
            end else if (pick < 92) begin
                b = 8'($urandom);
                if (b == HDR_SECOND)
                    b = HDR_FIRST;
                send_byte(HDR_FIRST);
                send_byte(b);
                items += 2;
            end else begin
                pick = $urandom_range(1, 4);
                repeat (pick) send_byte(8'($urandom));
                items += pick;
            end
            if ($urandom_range(0, 39) == 0)
                set_function(8'($urandom));
            else if ($urandom_range(0, 29) == 0)
                wait_for_replies();
        end
        tx_gap_max = 9;
        rx_gap_max = 9;
        wait_for_replies();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_function_codes();
        test_backpressure();
        test_drain_pause();
        test_random_stream(RANDOM_ITEMS);
        wait_for_replies();
        repeat (LATENCY * 3) @(posedge i_clk);
        $display("run covered %0d bytes taken, %0d replies checked (%0d with bad checksum)",
                 bytes_taken, replies_checked, bad_cks_replies);
        $display("function code register written %0d times, incl. 0x00 and 0xff",
                 func_writes);
        if (fail_count == 0 && reply_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (reply_q.size() != 0)
                $display("%0t: %0d replies never arrived", $time, reply_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d replies outstanding", $time, reply_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: reply_frame_receiver_unit.f
hw/rtl/rfr_pkg.sv
hw/rtl/rfr_deframer.sv
hw/rtl/reply_frame_receiver_unit.sv
tb/sv/tb_reply_frame_receiver_unit.sv
